FILE: rtl/bbs_pkg.sv
package bbs_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH);
  localparam int unsigned ADDR_W      = 3;

  localparam logic [VALUE_WIDTH-1:0] MODULUS_RST = VALUE_WIDTH'(21);
  localparam logic [VALUE_WIDTH-1:0] SEED_RST    = VALUE_WIDTH'(5);

  // register indexes
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_SEED    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_DBL,
    S_ADD,
    S_DONE
  } state_t;

endpackage

FILE: rtl/modular_squaring_random_generator_top.sv
// Channel | Ports                            | Beat
// --------+----------------------------------+-----------------------------------
// input   | in_valid, in_stall, in_restart   | one command: restart or advance
// output  | out_valid, out_stall, out_number | one generated value per command
// config  | psel, penable, pwrite, paddr,    | 0x0 modulus, 0x4 seed
//         | pwdata, prdata, pready           |
//
// A restart, or an advance with modulus zero, needs no arithmetic and goes straight to the done state.
// An advance reduces the state mod M bit by bit, then squares it by double-and-add
// (a double for every bit, and an add after each set bit of the reduced state),
// all through one shared modular adder. in_stall is high from accept until the result is
// in the output register; a stalled output holds the block in its final state.
// Reset (rst_n, synchronous) clears the state to zero and loads modulus 21, seed 5.
module modular_squaring_random_generator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bbs_pkg::VALUE_WIDTH-1:0] out_number,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bbs_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import bbs_pkg::*;

  state_t                   state_r, state_nxt;
  logic [VALUE_WIDTH-1:0]   modulus_r, seed_r;
  logic [VALUE_WIDTH-1:0]   cur_r, cur_nxt;    // generator state
  logic [VALUE_WIDTH-1:0]   red_r, red_nxt;    // state mod M
  logic [VALUE_WIDTH-1:0]   acc_r, acc_nxt;    // squaring accumulator
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;    // bit position, MSB first
  logic                     out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0]   out_number_r, out_number_nxt;

  logic                     accept;
  logic                     wr_en;
  logic                     last_bit;
  logic                     out_free;

  // shared modular adder: (op_a + op_b + op_cin) mod M, for op_a, op_b < M
  logic [VALUE_WIDTH-1:0]   op_a, op_b;
  logic                     op_cin;
  logic [VALUE_WIDTH:0]     sum, diff;
  logic [VALUE_WIDTH-1:0]   unit_res;

  assign accept   = in_valid && !in_stall;
  assign wr_en    = psel && penable && pwrite && pready;
  assign last_bit = (cnt_r == '0);
  assign out_free = !out_valid_r || !out_stall;

  assign sum      = {1'b0, op_a} + {1'b0, op_b} + {{VALUE_WIDTH{1'b0}}, op_cin};
  assign diff     = sum - {1'b0, modulus_r};
  assign unit_res = diff[VALUE_WIDTH] ? sum[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];

  // --- configuration port ---
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_MODULUS: prdata[VALUE_WIDTH-1:0] = modulus_r;
      REG_SEED:    prdata[VALUE_WIDTH-1:0] = seed_r;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RST;
      seed_r    <= SEED_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MODULUS: modulus_r <= pwdata[VALUE_WIDTH-1:0];
        REG_SEED:    seed_r    <= pwdata[VALUE_WIDTH-1:0];
        default:     ;
      endcase
    end
  end

  // --- next state ---
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // restart and zero modulus need no arithmetic
          if (in_restart || modulus_r == '0) state_nxt = S_DONE;
          else                               state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (last_bit) state_nxt = S_DBL;
      end
      S_DBL: begin
        if (red_r[cnt_r])  state_nxt = S_ADD;
        else if (last_bit) state_nxt = S_DONE;
      end
      S_ADD: begin
        if (last_bit) state_nxt = S_DONE;
        else          state_nxt = S_DBL;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --- datapath and outputs ---
  always_comb begin
    cur_nxt        = cur_r;
    red_nxt        = red_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    op_a           = acc_r;
    op_b           = acc_r;
    op_cin         = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_number_nxt = out_number_r;
    in_stall       = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          red_nxt = '0;
          cnt_nxt = CNT_W'(VALUE_WIDTH - 1);
          if (in_restart)             cur_nxt = seed_r;
          else if (modulus_r == '0)   cur_nxt = '0;
        end
      end
      S_RED: begin
        // shift in one state bit and subtract M if it overflows
        op_a    = red_r;
        op_b    = red_r;
        op_cin  = cur_r[cnt_r];
        red_nxt = unit_res;
        acc_nxt = '0;
        cnt_nxt = last_bit ? CNT_W'(VALUE_WIDTH - 1) : cnt_r - 1'b1;
      end
      S_DBL: begin
        acc_nxt = unit_res;
        if (!red_r[cnt_r]) begin
          if (last_bit) cur_nxt = unit_res;
          else          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_ADD: begin
        op_b    = red_r;
        acc_nxt = unit_res;
        if (last_bit) cur_nxt = unit_res;
        else          cnt_nxt = cnt_r - 1'b1;
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_number_nxt = cur_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r        <= red_nxt;
    acc_r        <= acc_nxt;
    cnt_r        <= cnt_nxt;
    out_number_r <= out_number_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_number = out_number_r;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bbs_pkg::*;

  localparam int VW             = VALUE_WIDTH;
  localparam int IDLE_PCT       = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  // Slack after the final drain, longer than the slowest advance takes.
  localparam int DRAIN_CYCLES   = 3 * VW + 12;
  localparam int RAND_PHASES    = 14;
  localparam int QUIET_PHASE    = 5;  // no idling on either side
  localparam int HOLD_PHASE     = 3;  // sender holds off until drained

  typedef logic [VW-1:0] value_t;

  typedef enum logic {
    ROW_STEP,
    ROW_WRITE
  } row_kind_t;

  // One row of the directed plan. For ROW_STEP, value is the typed-in
  // number when check is set; for ROW_WRITE it is the register data.
  typedef struct packed {
    row_kind_t kind;
    logic      restart;
    logic      reg_idx;
    logic      check;
    value_t    value;
  } plan_row_t;

  localparam plan_row_t DIRECTED_PLAN [0:28] = '{
    // Fresh out of reset: state is zero, so advancing gives zero.
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b1, 32'h0000_0000},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b1, 32'h0000_0000},
    // Restart loads the reset seed, then walk a few squarings mod 21.
    '{ROW_STEP,  1'b1, REG_MODULUS, 1'b1, 32'h0000_0005},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b0, 32'h0},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b0, 32'h0},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b0, 32'h0},
    // Seed above the modulus: emitted unreduced, reduced on the next advance.
    '{ROW_WRITE, 1'b0, REG_SEED,    1'b0, 32'hFFFF_FFFF},
    '{ROW_STEP,  1'b1, REG_MODULUS, 1'b1, 32'hFFFF_FFFF},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b0, 32'h0},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b0, 32'h0},
    // Modulus zero: advancing clears the state.
    '{ROW_WRITE, 1'b0, REG_MODULUS, 1'b0, 32'h0000_0000},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b1, 32'h0000_0000},
    '{ROW_STEP,  1'b1, REG_MODULUS, 1'b1, 32'hFFFF_FFFF},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b1, 32'h0000_0000},
    // Modulus one: every advance is zero.
    '{ROW_WRITE, 1'b0, REG_MODULUS, 1'b0, 32'h0000_0001},
    '{ROW_STEP,  1'b1, REG_MODULUS, 1'b1, 32'hFFFF_FFFF},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b1, 32'h0000_0000},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b1, 32'h0000_0000},
    // Largest modulus, seed just below it.
    '{ROW_WRITE, 1'b0, REG_MODULUS, 1'b0, 32'hFFFF_FFFF},
    '{ROW_WRITE, 1'b0, REG_SEED,    1'b0, 32'hFFFF_FFFE},
    '{ROW_STEP,  1'b1, REG_MODULUS, 1'b1, 32'hFFFF_FFFE},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b0, 32'h0},
    '{ROW_STEP,  1'b1, REG_MODULUS, 1'b1, 32'hFFFF_FFFE},
    // Modulus two with a state far above it.
    '{ROW_WRITE, 1'b0, REG_MODULUS, 1'b0, 32'h0000_0002},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b0, 32'h0},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b0, 32'h0},
    // Zero seed stays at zero.
    '{ROW_WRITE, 1'b0, REG_SEED,    1'b0, 32'h0000_0000},
    '{ROW_STEP,  1'b1, REG_MODULUS, 1'b1, 32'h0000_0000},
    '{ROW_STEP,  1'b0, REG_MODULUS, 1'b1, 32'h0000_0000}
  };

  // Primes congruent to three mod four; any pair multiplies below 2^32.
  localparam int unsigned BLUM_PRIMES [0:9] = '{
    7, 11, 19, 23, 499, 503, 547, 607, 1019, 65519
  };

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  value_t               out_number;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [ADDR_W-1:0]    paddr      = '0;
  logic [31:0]          pwdata     = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Shadow of the block: registers and generator state.
  value_t modulus_shadow = MODULUS_RST;
  value_t seed_shadow    = SEED_RST;
  value_t bbs_state      = '0;

  // Numbers still owed by the block, oldest first.
  value_t pending_numbers [$];

  bit no_idle = 1'b0;
  int n_err = 0;
  int n_restart = 0;
  int n_advance = 0;
  int n_numbers = 0;
  int n_writes = 0;
  int quiet_cycles = 0;

  modular_squaring_random_generator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_number (out_number),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Roll the dice for one idle cycle; never idle during the quiet stretch.
  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Advance the shadow generator by one command and return the number it emits.
  // The square of a 32-bit residue fits in 64 bits, so reduce directly.
  function automatic value_t next_number(logic restart);
    logic [63:0] base;
    logic [63:0] square;
    if (restart) begin
      bbs_state = seed_shadow;
    end else if (modulus_shadow == '0) begin
      bbs_state = '0;
    end else begin
      base      = 64'(bbs_state) % 64'(modulus_shadow);
      square    = base * base;
      bbs_state = value_t'(square % 64'(modulus_shadow));
    end
    return bbs_state;
  endfunction

  // Drive one command beat. Idle first at random, then hold the beat until the
  // block takes it, and queue the number it owes us.
  task automatic send_beat(input logic restart, input logic check, input value_t typed);
    value_t predicted;
    if (idle_now()) begin
      in_valid <= 1'b0;
      if ($urandom_range(39) == 0) begin
        // Occasional long gap so the next command lands on an idle block.
        repeat ($urandom_range(20, 130)) @(posedge clk);
      end else begin
        do @(posedge clk); while (idle_now());
      end
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    predicted = next_number(restart);
    pending_numbers.push_back(check ? typed : predicted);
    if (restart) n_restart++;
    else n_advance++;
  endtask

  // Drop valid and wait for every owed number to come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_numbers.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write one register while the block is idle, then read it back.
  task automatic cfg_write(input logic reg_idx, input value_t value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({reg_idx, 2'b00});
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_MODULUS) modulus_shadow = value;
    else seed_shadow = value;
    n_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(value)) begin
      n_err++;
      $display("%0t: readback of register %0d: expected %h, got %h",
               $time, reg_idx, value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: stall the number channel at random, except in the quiet stretch.
  always @(posedge clk) begin
    out_stall <= idle_now();
  end

  // Compare every accepted number with the oldest one owed.
  always @(posedge clk) begin : number_check
    value_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_numbers++;
      if (pending_numbers.size() == 0) begin
        n_err++;
        $display("%0t: number %h arrived with nothing pending", $time, out_number);
      end else begin
        want = pending_numbers.pop_front();
        if (out_number !== want) begin
          n_err++;
          $display("%0t: number mismatch: expected %h, got %h", $time, want, out_number);
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on any port; give up past the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: %0d cycles without a beat, %0d numbers pending",
               $time, quiet_cycles, pending_numbers.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int          n_items;
    int unsigned p_idx;
    int unsigned q_idx;
    value_t      mod_pick;
    value_t      seed_pick;
    logic        restart;

    // Hold reset, then release it for good.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan: reset state, extremes and each corner of the arithmetic.
    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].kind == ROW_WRITE) begin
        cfg_write(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].value);
      end else begin
        send_beat(DIRECTED_PLAN[i].restart, DIRECTED_PLAN[i].check,
                  DIRECTED_PLAN[i].value);
      end
    end

    // Random phases: a fresh modulus and seed each time, then mostly long
    // squaring runs with an occasional restart. Phases that skip the opening
    // restart carry the old state into the new modulus.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(11))
        0:       mod_pick = '0;
        1:       mod_pick = value_t'(1);
        2:       mod_pick = value_t'(2);
        3:       mod_pick = '1;
        4, 5, 6: begin
          p_idx    = $urandom_range(9);
          q_idx    = $urandom_range(9);
          mod_pick = value_t'(BLUM_PRIMES[p_idx] * BLUM_PRIMES[q_idx]);
        end
        7:       mod_pick = value_t'($urandom_range(3, 255));
        default: mod_pick = value_t'($urandom);
      endcase
      case ($urandom_range(5))
        0:       seed_pick = '0;
        1:       seed_pick = '1;
        2, 3:    seed_pick = (mod_pick > 1) ? value_t'($urandom) % mod_pick
                                            : value_t'($urandom);
        default: seed_pick = value_t'($urandom);
      endcase

      no_idle = (ph == QUIET_PHASE);
      cfg_write(REG_MODULUS, mod_pick);
      cfg_write(REG_SEED, seed_pick);

      n_items = $urandom_range(100, 140);
      for (int k = 0; k < n_items; k++) begin
        // Hold off mid-phase until the block has handed back everything.
        if (ph == HOLD_PHASE && k == n_items / 2) wait_drained();
        restart = (k == 0 && $urandom_range(3) != 0) || ($urandom_range(11) == 0);
        send_beat(restart, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    // Drain what is owed, then linger in case anything extra shows up.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d restarts and %0d advances over %0d register writes;",
             n_restart, n_advance, n_writes);
    $display("%0d numbers checked across %0d moduli including 0, 1, 2 and all-ones.",
             n_numbers, RAND_PHASES + 5);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
